FILE: src/dgas_pkg.sv
// ----------------------------------------------------------------------------
// dgas_pkg
// Shared types and constants for the directed graph adjacency store.
// ----------------------------------------------------------------------------
package dgas_pkg;

    // vertex ids are 6 bits wide, so rows hold one bit per possible id
    localparam int MAX_VERTICES = 64;
    localparam int ID_W         = 6;
    localparam int ROW_W        = 2 ** ID_W;
    localparam int CNT_W        = 7;
    localparam int EDGE_W       = 13;
    localparam int BYTE_W       = 23;
    localparam int CFG_W        = 10;
    localparam int PROD_W       = CNT_W + CFG_W;

    localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};
    localparam logic [ROW_W-1:0]  ROW_ONE  = {{(ROW_W-1){1'b0}}, 1'b1};

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_VERTEX_BYTES = 1'b0;
    localparam logic REG_EDGE_BYTES   = 1'b1;
    localparam logic [CFG_W-1:0] VERTEX_BYTES_RST = 10'd64;
    localparam logic [CFG_W-1:0] EDGE_BYTES_RST   = 10'd12;

    // input mode codes
    localparam logic [2:0] MODE_ADD_V  = 3'd0;
    localparam logic [2:0] MODE_REM_V  = 3'd1;
    localparam logic [2:0] MODE_ADD_E  = 3'd2;
    localparam logic [2:0] MODE_REM_E  = 3'd3;
    localparam logic [2:0] MODE_TEST_V = 3'd4;
    localparam logic [2:0] MODE_TEST_E = 3'd5;
    localparam logic [2:0] MODE_LIST   = 3'd6;

    typedef enum logic [2:0] {
        OP_ADD_V,
        OP_REM_V,
        OP_ADD_E,
        OP_REM_E,
        OP_TEST_V,
        OP_TEST_E,
        OP_LIST,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] src;
        logic [ID_W-1:0] tgt;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEL_WALK,
        ST_DEL_MUL,
        ST_DEL_SUB,
        ST_LIST,
        ST_EMIT
    } t_bstate;

endpackage

FILE: src/dgas_front.sv
// ----------------------------------------------------------------------------
// dgas_front
// Accepts input words, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module dgas_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic [dgas_pkg::ID_W-1:0] i_source_vertex,
    input  logic [dgas_pkg::ID_W-1:0] i_target_vertex,
    output dgas_pkg::t_cmd     o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_pop
);

    dgas_pkg::t_cmd r_q [dgas_pkg::QDEPTH];
    logic [dgas_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [dgas_pkg::QCNT_W-1:0] r_count;
    dgas_pkg::t_cmd cmd_in;
    logic push;

    always_comb begin
        cmd_in.src = i_source_vertex;
        cmd_in.tgt = i_target_vertex;
        case (i_mode)
            dgas_pkg::MODE_ADD_V:  cmd_in.op = dgas_pkg::OP_ADD_V;
            dgas_pkg::MODE_REM_V:  cmd_in.op = dgas_pkg::OP_REM_V;
            dgas_pkg::MODE_ADD_E:  cmd_in.op = dgas_pkg::OP_ADD_E;
            dgas_pkg::MODE_REM_E:  cmd_in.op = dgas_pkg::OP_REM_E;
            dgas_pkg::MODE_TEST_V: cmd_in.op = dgas_pkg::OP_TEST_V;
            dgas_pkg::MODE_TEST_E: cmd_in.op = dgas_pkg::OP_TEST_E;
            dgas_pkg::MODE_LIST:   cmd_in.op = dgas_pkg::OP_LIST;
            default:               cmd_in.op = dgas_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_count == dgas_pkg::QCNT_W'(dgas_pkg::QDEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == dgas_pkg::QPTR_W'(dgas_pkg::QDEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == dgas_pkg::QPTR_W'(dgas_pkg::QDEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd_in;
        end
    end

endmodule

FILE: src/dgas_back.sv
// ----------------------------------------------------------------------------
// dgas_back
// Executes queued commands against the edge matrix and running counts.
// ----------------------------------------------------------------------------
module dgas_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dgas_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_pop,
    input  logic [dgas_pkg::CFG_W-1:0]    i_vertex_bytes,
    input  logic [dgas_pkg::CFG_W-1:0]    i_edge_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_ok,
    output logic [dgas_pkg::ID_W-1:0]     o_new_vertex_id,
    output logic [dgas_pkg::ID_W-1:0]     o_neighbor_id,
    output logic                          o_last,
    output logic [dgas_pkg::CNT_W-1:0]    o_vertex_bound,
    output logic [dgas_pkg::CNT_W-1:0]    o_live_vertices,
    output logic [dgas_pkg::EDGE_W-1:0]   o_edges_total,
    output logic [dgas_pkg::BYTE_W-1:0]   o_memory_used
);

    localparam int ID_W   = dgas_pkg::ID_W;
    localparam int ROW_W  = dgas_pkg::ROW_W;
    localparam int CNT_W  = dgas_pkg::CNT_W;
    localparam int EDGE_W = dgas_pkg::EDGE_W;
    localparam int BYTE_W = dgas_pkg::BYTE_W;
    localparam int PROD_W = dgas_pkg::PROD_W;

    function automatic logic [CNT_W-1:0] popcnt(input logic [ROW_W-1:0] row);
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < ROW_W; i++) begin
            sum = sum + CNT_W'(row[i]);
        end
        return sum;
    endfunction

    function automatic logic [ID_W-1:0] lsb_index(input logic [ROW_W-1:0] row);
        logic [ID_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (row[i]) begin
                idx = ID_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] b,
                                                   input logic [dgas_pkg::CFG_W-1:0] a);
        logic [BYTE_W:0] sum;
        sum = {1'b0, b} + (BYTE_W + 1)'(a);
        return (sum > {1'b0, dgas_pkg::BYTE_MAX}) ? dgas_pkg::BYTE_MAX : sum[BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] sat_sub(input logic [BYTE_W-1:0] b,
                                                   input logic [PROD_W-1:0] a);
        return (BYTE_W'(a) > b) ? '0 : b - BYTE_W'(a);
    endfunction

    // edge matrix: one row per source vertex
    logic [ROW_W-1:0] r_edge_mem [ROW_W];
    logic [ROW_W-1:0] r_rd_data;
    logic             mem_we, mem_re;
    logic [ID_W-1:0]  mem_waddr, mem_raddr;
    logic [ROW_W-1:0] mem_wdata;

    dgas_pkg::t_bstate r_state, n_state;
    dgas_pkg::t_cmd    r_cmd, n_cmd;
    logic [ROW_W-1:0]  r_deleted, n_deleted;
    logic [CNT_W-1:0]  r_alloc, n_alloc;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [EDGE_W-1:0] r_edges, n_edges;
    logic [BYTE_W-1:0] r_bytes, n_bytes;
    logic              r_res_ok, n_res_ok;
    logic [ID_W-1:0]   r_res_nid, n_res_nid;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ID_W-1:0]   r_v, n_v;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_prod, n_prod;

    logic r_o_valid, r_o_ok, r_o_last;
    logic [ID_W-1:0]   r_o_nid, r_o_nb;
    logic [CNT_W-1:0]  r_o_bound, r_o_live;
    logic [EDGE_W-1:0] r_o_edges;
    logic [BYTE_W-1:0] r_o_bytes;

    logic              out_free, out_load, out_ok, out_last;
    logic [ID_W-1:0]   out_nid, out_nb;
    logic              src_ok, tgt_ok, edge_bit;
    logic [ROW_W-1:0]  tgt_mask, src_mask, row_rest;

    assign out_free = !r_o_valid || !i_out_stall;
    assign src_ok   = ({1'b0, r_cmd.src} < r_alloc) && !r_deleted[r_cmd.src];
    assign tgt_ok   = ({1'b0, r_cmd.tgt} < r_alloc) && !r_deleted[r_cmd.tgt];
    assign edge_bit = r_rd_data[r_cmd.tgt];
    assign tgt_mask = dgas_pkg::ROW_ONE << r_cmd.tgt;
    assign src_mask = dgas_pkg::ROW_ONE << r_cmd.src;
    assign row_rest = r_row & (r_row - dgas_pkg::ROW_ONE);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_deleted = r_deleted;
        n_alloc   = r_alloc;
        n_live    = r_live;
        n_edges   = r_edges;
        n_bytes   = r_bytes;
        n_res_ok  = r_res_ok;
        n_res_nid = r_res_nid;
        n_row     = r_row;
        n_v       = r_v;
        n_cnt     = r_cnt;
        n_prod    = r_prod;
        mem_we    = 1'b0;
        mem_waddr = r_cmd.src;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_cmd.src;
        o_pop     = 1'b0;
        out_load  = 1'b0;
        out_ok    = 1'b0;
        out_nid   = '0;
        out_nb    = '0;
        out_last  = 1'b1;

        case (r_state)
            dgas_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd;
                    mem_re    = 1'b1;
                    mem_raddr = i_cmd.src;
                    n_state   = dgas_pkg::ST_EXEC;
                end
            end
            dgas_pkg::ST_EXEC: begin
                n_state   = dgas_pkg::ST_EMIT;
                n_res_ok  = 1'b0;
                n_res_nid = '0;
                case (r_cmd.op)
                    dgas_pkg::OP_ADD_V: begin
                        if (r_alloc < CNT_W'(dgas_pkg::MAX_VERTICES)) begin
                            // fresh row starts empty
                            mem_we    = 1'b1;
                            mem_waddr = r_alloc[ID_W-1:0];
                            mem_wdata = '0;
                            n_res_nid = r_alloc[ID_W-1:0];
                            n_alloc   = r_alloc + 1'b1;
                            n_live    = r_live + 1'b1;
                            n_bytes   = sat_add(r_bytes, i_vertex_bytes);
                            n_res_ok  = 1'b1;
                        end
                    end
                    dgas_pkg::OP_REM_V: begin
                        if (src_ok) begin
                            n_cnt     = popcnt(r_rd_data);
                            mem_we    = 1'b1;
                            mem_wdata = '0;
                            n_deleted = r_deleted | src_mask;
                            n_live    = r_live - 1'b1;
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_v       = '0;
                            n_res_ok  = 1'b1;
                            n_state   = dgas_pkg::ST_DEL_WALK;
                        end
                    end
                    dgas_pkg::OP_ADD_E: begin
                        if (src_ok && tgt_ok && !edge_bit) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_rd_data | tgt_mask;
                            n_edges   = r_edges + 1'b1;
                            n_bytes   = sat_add(r_bytes, i_edge_bytes);
                            n_res_ok  = 1'b1;
                        end
                    end
                    dgas_pkg::OP_REM_E: begin
                        if (src_ok && tgt_ok && edge_bit) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_rd_data & ~tgt_mask;
                            n_edges   = r_edges - 1'b1;
                            n_bytes   = sat_sub(r_bytes, PROD_W'(i_edge_bytes));
                            n_res_ok  = 1'b1;
                        end
                    end
                    dgas_pkg::OP_TEST_V: begin
                        n_res_ok = src_ok;
                    end
                    dgas_pkg::OP_TEST_E: begin
                        n_res_ok = src_ok && tgt_ok && edge_bit;
                    end
                    dgas_pkg::OP_LIST: begin
                        if (src_ok && (r_rd_data != '0)) begin
                            n_row   = r_rd_data;
                            n_state = dgas_pkg::ST_LIST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dgas_pkg::ST_DEL_WALK: begin
                // r_rd_data holds row r_v; the next row is fetched alongside
                if ((r_v != r_cmd.src) && !r_deleted[r_v] && r_rd_data[r_cmd.src]) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_v;
                    mem_wdata = r_rd_data & ~src_mask;
                    n_cnt     = r_cnt + 1'b1;
                end
                if (({1'b0, r_v} + 1'b1) < r_alloc) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_v + 1'b1;
                    n_v       = r_v + 1'b1;
                end else begin
                    n_state = dgas_pkg::ST_DEL_MUL;
                end
            end
            dgas_pkg::ST_DEL_MUL: begin
                n_prod  = PROD_W'(r_cnt) * PROD_W'(i_edge_bytes);
                n_edges = r_edges - EDGE_W'(r_cnt);
                n_state = dgas_pkg::ST_DEL_SUB;
            end
            dgas_pkg::ST_DEL_SUB: begin
                // one clamped subtraction equals the per-edge clamped steps
                n_bytes = sat_sub(r_bytes, r_prod);
                n_state = dgas_pkg::ST_EMIT;
            end
            dgas_pkg::ST_LIST: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_ok   = 1'b1;
                    out_nb   = lsb_index(r_row);
                    out_last = (row_rest == '0);
                    n_row    = row_rest;
                    if (row_rest == '0) begin
                        n_state = dgas_pkg::ST_IDLE;
                    end
                end
            end
            dgas_pkg::ST_EMIT: begin
            end
            default: begin
                n_state = dgas_pkg::ST_IDLE;
            end
        endcase

        // single result word carrying the counts as they stand after the op
        if ((n_state == dgas_pkg::ST_EMIT) && out_free) begin
            out_load = 1'b1;
            out_ok   = n_res_ok;
            out_nid  = n_res_nid;
            out_nb   = '0;
            out_last = 1'b1;
            n_state  = dgas_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_edge_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_edge_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dgas_pkg::ST_IDLE;
            r_deleted <= '0;
            r_alloc   <= '0;
            r_live    <= '0;
            r_edges   <= '0;
            r_bytes   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_deleted <= n_deleted;
            r_alloc   <= n_alloc;
            r_live    <= n_live;
            r_edges   <= n_edges;
            r_bytes   <= n_bytes;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_res_ok  <= n_res_ok;
        r_res_nid <= n_res_nid;
        r_row     <= n_row;
        r_v       <= n_v;
        r_cnt     <= n_cnt;
        r_prod    <= n_prod;
        if (out_load) begin
            r_o_ok    <= out_ok;
            r_o_nid   <= out_nid;
            r_o_nb    <= out_nb;
            r_o_last  <= out_last;
            r_o_bound <= n_alloc;
            r_o_live  <= n_live;
            r_o_edges <= n_edges;
            r_o_bytes <= n_bytes;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_ok            = r_o_ok;
    assign o_new_vertex_id = r_o_nid;
    assign o_neighbor_id   = r_o_nb;
    assign o_last          = r_o_last;
    assign o_vertex_bound  = r_o_bound;
    assign o_live_vertices = r_o_live;
    assign o_edges_total   = r_o_edges;
    assign o_memory_used   = r_o_bytes;

    a_live_le_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_alloc)
        else $error("live count exceeds allocated count");

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= CNT_W'(dgas_pkg::MAX_VERTICES))
        else $error("allocated count beyond capacity");

    a_list_row_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dgas_pkg::ST_LIST) |-> (r_row != '0))
        else $error("listing with an empty row");

    a_not_last_is_neighbour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_last) |-> r_o_ok)
        else $error("non-final word without a valid neighbour");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == dgas_pkg::ST_EXEC))
        else $error("command popped outside idle");

endmodule

FILE: src/dynamic_graph_adjacency_store.sv
// ----------------------------------------------------------------------------
// dynamic_graph_adjacency_store
// Directed graph store: edge bit matrix, deleted marks and running counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one command word per
//   handshake: mode, source and target vertex. A two-entry queue sits behind
//   it, so commands are taken while the back end is still busy.
//   Output channel (o_out_valid / i_out_stall) returns one or more result
//   words per command, o_last marking the final one; listing yields one word
//   per neighbour in ascending order.
//   Flow: a simple command runs in the back end as a matrix row read, then
//   update and result. Listing then emits one word per neighbour, one per
//   cycle while i_out_stall is low. Vertex deletion walks every allocated
//   row, one per cycle, then scales and subtracts the freed edge bytes. The
//   edge matrix takes one row read and one row write per cycle.
//   The output register holds a word while i_out_stall is high; the back end
//   then waits and the input queue fills up until o_in_stall rises.
//   Reset clears the counts and deleted marks; matrix rows are zeroed as each
//   vertex is allocated. Registers vertex_bytes (0x0) and edge_bytes (0x4) return
//   to 64 and 12; the user must write them over the APB port only while idle.
// ----------------------------------------------------------------------------
module dynamic_graph_adjacency_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dgas_pkg::PADDR_W-1:0]      paddr,
    input  logic [dgas_pkg::PDATA_W-1:0]      pwdata,
    output logic [dgas_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_mode,
    input  logic [dgas_pkg::ID_W-1:0]         i_source_vertex,
    input  logic [dgas_pkg::ID_W-1:0]         i_target_vertex,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_ok,
    output logic [dgas_pkg::ID_W-1:0]         o_new_vertex_id,
    output logic [dgas_pkg::ID_W-1:0]         o_neighbor_id,
    output logic                              o_last,
    output logic [dgas_pkg::CNT_W-1:0]        o_vertex_bound,
    output logic [dgas_pkg::CNT_W-1:0]        o_live_vertices,
    output logic [dgas_pkg::EDGE_W-1:0]       o_edges_total,
    output logic [dgas_pkg::BYTE_W-1:0]       o_memory_used
);

    logic [dgas_pkg::CFG_W-1:0] r_vertex_bytes, r_edge_bytes;
    logic           cfg_wr;
    dgas_pkg::t_cmd cmd;
    logic           cmd_valid, pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_bytes <= dgas_pkg::VERTEX_BYTES_RST;
            r_edge_bytes   <= dgas_pkg::EDGE_BYTES_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                dgas_pkg::REG_VERTEX_BYTES: r_vertex_bytes <= pwdata[dgas_pkg::CFG_W-1:0];
                dgas_pkg::REG_EDGE_BYTES:   r_edge_bytes   <= pwdata[dgas_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dgas_pkg::REG_VERTEX_BYTES: prdata = dgas_pkg::PDATA_W'(r_vertex_bytes);
            dgas_pkg::REG_EDGE_BYTES:   prdata = dgas_pkg::PDATA_W'(r_edge_bytes);
            default:                    prdata = '0;
        endcase
    end

    dgas_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_source_vertex (i_source_vertex),
        .i_target_vertex (i_target_vertex),
        .o_cmd           (cmd),
        .o_cmd_valid     (cmd_valid),
        .i_pop           (pop)
    );

    dgas_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cmd_valid     (cmd_valid),
        .o_pop           (pop),
        .i_vertex_bytes  (r_vertex_bytes),
        .i_edge_bytes    (r_edge_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_new_vertex_id (o_new_vertex_id),
        .o_neighbor_id   (o_neighbor_id),
        .o_last          (o_last),
        .o_vertex_bound  (o_vertex_bound),
        .o_live_vertices (o_live_vertices),
        .o_edges_total   (o_edges_total),
        .o_memory_used   (o_memory_used)
    );

endmodule
